FILE: hdl/assert_macros.svh
// Assertion macros shared by the keyed block allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/kba_pkg.sv
// Types and constants for the keyed block allocator
package kba_pkg;

	localparam int KBA_MAX_ENTRIES = 64;
	localparam int KBA_POOL_BYTES  = 65536;

	localparam int KEY_W  = 32;
	localparam int SIZE_W = 13;
	localparam int OFF_W  = 16;

	typedef enum logic [1:0] {
		FUNC_ATTACH = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_TABLE_FULL = 2'd2,
		STAT_POOL_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] block_size;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [OFF_W-1:0] offset;
		logic             reused;
	} rsp_t;

	// one header table entry
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  offset;
		logic              used;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic match;
		logic done;
	} dp_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} kba_state_t;

endpackage

FILE: hdl/kba_ctrl.sv
// Controller for the keyed block allocator: request accept and scan sequencing
module kba_ctrl import kba_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	kba_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		busy       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				busy = 1'b1;
				if (sts.match || sts.done) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/kba_datapath.sv
// Datapath for the keyed block allocator: header table, scan pipeline, pool pointer
module kba_datapath import kba_pkg::*; #(
	parameter int MAX_ENTRIES = KBA_MAX_ENTRIES,
	parameter int POOL_BYTES  = KBA_POOL_BYTES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t    rsp,
	output logic    done
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TOP_W = $clog2(POOL_BYTES + 1);
	localparam int SUM_W = ((TOP_W > SIZE_W) ? TOP_W : SIZE_W) + 1;

	entry_t mem [MAX_ENTRIES];

	req_t             req_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] count_q;
	logic [TOP_W-1:0] pool_top_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_s1;
	logic             done_q;
	rsp_t             rsp_q;

	logic             rd_en;
	logic             hit;
	logic             we;
	logic [IDX_W-1:0] wa;
	entry_t           wd;
	rsp_t             rsp_d;
	logic             append;
	logic [SUM_W-1:0] top_sum;

	assign rd_en = cmd.scan && (addr_q < count_q);

	always_comb begin
		hit = 1'b0;
		case (req_q.func)
			FUNC_ATTACH: hit = !rd_s1.used && (rd_s1.size == req_q.block_size);
			FUNC_REMOVE,
			FUNC_LOOKUP: hit = rd_s1.used && (rd_s1.key == req_q.key);
			default:     hit = 1'b0;
		endcase
	end

	assign sts.match = vld_s1 && hit;
	assign sts.done  = !vld_s1 && (addr_q >= count_q);

	assign top_sum = SUM_W'(pool_top_q) + SUM_W'(req_q.block_size);

	// result and table update, decided in the commit cycle
	always_comb begin
		we            = 1'b0;
		wa            = idx_s1;
		wd            = rd_s1;
		append        = 1'b0;
		rsp_d.status  = STAT_NOT_FOUND;
		rsp_d.offset  = '0;
		rsp_d.reused  = 1'b0;
		if (sts.match) begin
			rsp_d.status = STAT_OK;
			rsp_d.offset = rd_s1.offset;
			case (req_q.func)
				FUNC_ATTACH: begin
					we           = 1'b1;
					wd.used      = 1'b1;
					wd.key       = req_q.key;
					rsp_d.reused = 1'b1;
				end
				FUNC_REMOVE: begin
					we      = 1'b1;
					wd.used = 1'b0;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end else if (req_q.func == FUNC_ATTACH) begin
			if (count_q == CNT_W'(MAX_ENTRIES)) begin
				rsp_d.status = STAT_TABLE_FULL;
			end else if (top_sum > SUM_W'(POOL_BYTES)) begin
				rsp_d.status = STAT_POOL_FULL;
			end else begin
				append       = 1'b1;
				we           = 1'b1;
				wa           = count_q[IDX_W-1:0];
				wd.key       = req_q.key;
				wd.size      = req_q.block_size;
				wd.offset    = OFF_W'(pool_top_q);
				wd.used      = 1'b1;
				rsp_d.status = STAT_OK;
				rsp_d.offset = OFF_W'(pool_top_q);
			end
		end
	end

	// header table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_s1  <= mem[addr_q[IDX_W-1:0]];
			idx_s1 <= addr_q[IDX_W-1:0];
		end
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			vld_s1     <= 1'b0;
			count_q    <= '0;
			pool_top_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.load) begin
				addr_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (cmd.commit && append) begin
				count_q    <= count_q + 1'b1;
				pool_top_q <= TOP_W'(top_sum);
			end
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

FILE: hdl/keyed_block_allocator_top.sv
// Sequence: accept loads the request, then headers are read in order from header 0, one
// header read per cycle, until a hit or the header count; the commit is registered into done.
// A new request is taken in the result cycle at the earliest, so requests never overlap.
// The receiver cannot stall; done lasts one cycle.
// Reset: arst_n clears the header count, pool top and controller; table contents
// are not cleared, since only headers below the count are ever read.
`include "assert_macros.svh"

module keyed_block_allocator_top import kba_pkg::*; #(
	parameter int MAX_ENTRIES = KBA_MAX_ENTRIES,
	parameter int POOL_BYTES  = KBA_POOL_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	kba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	kba_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.POOL_BYTES  (POOL_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

	`KBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request accepted but not busy")
	`KBA_ASSERT_IMPL(a_done_after_busy, clk, arst_n, done, $past(busy), "result without a scan")
	`KBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe repeated")
	`KBA_ASSERT_IMPL(a_commit_exclusive, clk, arst_n, cmd.commit, !cmd.scan && !cmd.load, "commit overlaps scan or load")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the keyed block allocator: directed, exhaustion and random tests
`timescale 1ns / 1ps

module tb import kba_pkg::*;;

	localparam int LIMIT_CYCLES = 400000;
	localparam int APPEND_CAP   = 36;	// header count below which mixed traffic may append new headers

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	keyed_block_allocator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// shadow of the header table and pool
	logic [KEY_W-1:0]  hdr_key  [KBA_MAX_ENTRIES];
	logic [SIZE_W-1:0] hdr_size [KBA_MAX_ENTRIES];
	logic [16:0]       hdr_off  [KBA_MAX_ENTRIES];
	logic              hdr_live [KBA_MAX_ENTRIES];
	int                hdr_count;
	int                pool_top;

	rsp_t answers_due [$];
	rsp_t last_answer;
	rsp_t want;
	bit   gaps_on;
	int   errors;
	int   cycles;
	int   n_requests;
	int   n_reused;
	int   stat_seen [4];

	logic [KEY_W-1:0] key_pool [12] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_1234, 32'hDEAD_0042,
		32'h7FFF_FFFF, 32'h0000_00FF, 32'h1357_9BDF, 32'hFFFF_0000};

	logic [SIZE_W-1:0] size_pool [12] = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd8,
		13'd16, 13'd32, 13'd64, 13'd100, 13'd255, 13'd256};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				answers_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic flag(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// result checker: every strobe is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				flag($sformatf("unexpected result status %0d offset %0h", rsp.status,
					rsp.offset));
			end else begin
				want = answers_due.pop_front();
				if (rsp.status !== want.status)
					flag($sformatf("status got %0d want %0d", rsp.status, want.status));
				if (rsp.offset !== want.offset)
					flag($sformatf("offset got %0h want %0h", rsp.offset, want.offset));
				if (rsp.reused !== want.reused)
					flag($sformatf("reused got %0b want %0b", rsp.reused, want.reused));
			end
		end
	end

	function automatic rsp_t predict_allocation(req_t r);
		rsp_t a;
		int hit;
		hit = -1;
		a.status = STAT_NOT_FOUND;
		a.offset = '0;
		a.reused = 1'b0;
		case (r.func)
			FUNC_ATTACH: begin
				for (int i = 0; i < hdr_count; i++)
					if (hit < 0 && !hdr_live[i] && hdr_size[i] == r.block_size)
						hit = i;
				if (hit >= 0) begin
					hdr_live[hit] = 1'b1;
					hdr_key[hit]  = r.key;
					a.status = STAT_OK;
					a.offset = hdr_off[hit][15:0];
					a.reused = 1'b1;
				end else if (hdr_count >= KBA_MAX_ENTRIES) begin
					a.status = STAT_TABLE_FULL;
				end else if (pool_top + int'(r.block_size) > KBA_POOL_BYTES) begin
					a.status = STAT_POOL_FULL;
				end else begin
					hdr_key[hdr_count]  = r.key;
					hdr_size[hdr_count] = r.block_size;
					hdr_off[hdr_count]  = pool_top[16:0];
					hdr_live[hdr_count] = 1'b1;
					hdr_count++;
					a.status = STAT_OK;
					a.offset = pool_top[15:0];
					pool_top += int'(r.block_size);
				end
			end
			FUNC_REMOVE, FUNC_LOOKUP: begin
				for (int i = 0; i < hdr_count; i++)
					if (hit < 0 && hdr_live[i] && hdr_key[i] == r.key)
						hit = i;
				if (hit >= 0) begin
					if (r.func == FUNC_REMOVE)
						hdr_live[hit] = 1'b0;
					a.status = STAT_OK;
					a.offset = hdr_off[hit][15:0];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic req_t mk_req(func_t f, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] s);
		req_t r;
		r.func       = f;
		r.key        = k;
		r.block_size = s;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, 11)];
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		return size_pool[$urandom_range(0, 11)];
	endfunction

	function automatic logic [SIZE_W-1:0] any_size();
		return SIZE_W'($urandom_range(0, 8191));
	endfunction

	// key of a random live header, else any key
	function automatic logic [KEY_W-1:0] live_key();
		int idx [$];
		for (int i = 0; i < hdr_count; i++)
			if (hdr_live[i])
				idx = {idx, i};
		if (idx.size() == 0)
			return pick_key();
		return hdr_key[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	// size of a random free header, -1 when none
	function automatic int free_size();
		int idx [$];
		for (int i = 0; i < hdr_count; i++)
			if (!hdr_live[i])
				idx = {idx, i};
		if (idx.size() == 0)
			return -1;
		return int'(hdr_size[idx[$urandom_range(0, idx.size() - 1)]]);
	endfunction

	function automatic logic [SIZE_W-1:0] used_size();
		int idx [$];
		for (int i = 0; i < hdr_count; i++)
			if (hdr_live[i])
				idx = {idx, i};
		if (idx.size() == 0)
			return pick_size();
		return hdr_size[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	// start stays high after accept so that back-to-back requests follow directly
	task automatic send(req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		last_answer = predict_allocation(r);
		answers_due = {answers_due, last_answer};
		n_requests++;
		stat_seen[last_answer.status]++;
		if (last_answer.reused)
			n_reused++;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic release_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send(mk_req(FUNC_LOOKUP, 32'h0000_0000, 13'd0));
		send(mk_req(FUNC_REMOVE, 32'hFFFF_FFFF, 13'h1FFF));
		send(mk_req(FUNC_NONE,   32'h0000_0005, 13'h1FFF));
		send(mk_req(FUNC_ATTACH, 32'h0000_0000, 13'd0));	// zero-length block
		send(mk_req(FUNC_ATTACH, 32'hFFFF_FFFF, 13'h1FFF));
		send(mk_req(FUNC_ATTACH, 32'h0000_1234, 13'd4096));
		send(mk_req(FUNC_ATTACH, 32'h0000_0000, 13'd1));	// duplicate key
		send(mk_req(FUNC_LOOKUP, 32'h0000_0000, 13'd0));
		send(mk_req(FUNC_REMOVE, 32'h0000_0000, 13'd0));
		send(mk_req(FUNC_LOOKUP, 32'h0000_0000, 13'd0));
		send(mk_req(FUNC_ATTACH, 32'h0000_004D, 13'd0));	// reuse of zero-size header
		send(mk_req(FUNC_REMOVE, 32'h0000_1234, 13'd7));
		send(mk_req(FUNC_REMOVE, 32'h0000_1234, 13'd7));
		send(mk_req(FUNC_ATTACH, 32'hA5A5_A5A5, 13'd4096));
		send(mk_req(FUNC_ATTACH, 32'h5A5A_5A5A, 13'd4096));
		send(mk_req(FUNC_LOOKUP, 32'hA5A5_A5A5, 13'h0AAA));
		send(mk_req(FUNC_NONE,   32'hA5A5_A5A5, 13'd0));
		send(mk_req(FUNC_REMOVE, 32'hFFFF_FFFF, 13'h1555));
		send(mk_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 13'd0));
		release_start();
	endtask

	task automatic test_mixed_traffic(int n);
		int pick;
		int fs;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (k == n / 2) begin
				release_start();
				wait_idle();
			end
			if (pick < 40) begin
				fs = free_size();
				if (hdr_count < APPEND_CAP)
					send(mk_req(FUNC_ATTACH, pick_key(), pick_size()));
				else if (fs >= 0)
					send(mk_req(FUNC_ATTACH, pick_key(), SIZE_W'(fs)));
				else
					send(mk_req(FUNC_REMOVE, live_key(), any_size()));
			end else if (pick < 65) begin
				send(mk_req(FUNC_REMOVE,
					($urandom_range(0, 4) == 0) ? pick_key() : live_key(), any_size()));
			end else if (pick < 92) begin
				send(mk_req(FUNC_LOOKUP,
					($urandom_range(0, 3) == 0) ? pick_key() : live_key(), any_size()));
			end else begin
				send(mk_req(FUNC_NONE, pick_key(), any_size()));
			end
		end
		release_start();
	endtask

	task automatic test_pool_exhaustion();
		logic [KEY_W-1:0] k;
		int rem;
		// hold off until the block has drained
		wait_idle();
		last_answer.status = STAT_OK;
		for (int i = 0; i < 12 && last_answer.status != STAT_POOL_FULL; i++)
			send(mk_req(FUNC_ATTACH, $urandom, 13'h1FFF));
		rem = KBA_POOL_BYTES - pool_top;
		if (rem > 0 && rem <= 8191)
			send(mk_req(FUNC_ATTACH, $urandom, SIZE_W'(rem)));	// exact fit
		send(mk_req(FUNC_ATTACH, $urandom, 13'd1));
		k = $urandom;
		// a zero-size block at the very top has an offset that wraps in 16 bits
		send(mk_req(FUNC_ATTACH, k, 13'd0));
		send(mk_req(FUNC_LOOKUP, k, 13'd0));
		send(mk_req(FUNC_ATTACH, $urandom, 13'd8190));
		release_start();
	endtask

	task automatic test_table_full();
		int fs;
		for (int i = 0; i < 120 && hdr_count < KBA_MAX_ENTRIES; i++)
			send(mk_req(FUNC_ATTACH, $urandom, 13'd0));
		// table full must win over pool full
		send(mk_req(FUNC_ATTACH, $urandom, 13'd4095));
		send(mk_req(FUNC_REMOVE, live_key(), 13'd0));
		fs = free_size();
		if (fs >= 0)
			send(mk_req(FUNC_ATTACH, 32'h0BAD_F00D, SIZE_W'(fs)));
		send(mk_req(FUNC_LOOKUP, 32'h0BAD_F00D, 13'd0));
		release_start();
	endtask

	task automatic test_full_table_traffic(int n, int quiet_tail);
		int pick;
		int fs;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (k == n - quiet_tail)
				gaps_on = 1'b0;
			if (pick < 40) begin
				fs = free_size();
				pick = $urandom_range(0, 99);
				if (pick < 60 && fs >= 0)
					send(mk_req(FUNC_ATTACH, pick_key(), SIZE_W'(fs)));
				else if (pick < 85)
					send(mk_req(FUNC_ATTACH, pick_key(), used_size()));
				else
					send(mk_req(FUNC_ATTACH, pick_key(), any_size()));
			end else if (pick < 65) begin
				send(mk_req(FUNC_REMOVE,
					($urandom_range(0, 4) == 0) ? pick_key() : live_key(), any_size()));
			end else if (pick < 90) begin
				send(mk_req(FUNC_LOOKUP,
					($urandom_range(0, 3) == 0) ? pick_key() : live_key(), any_size()));
			end else begin
				send(mk_req(FUNC_NONE, pick_key(), any_size()));
			end
		end
		release_start();
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		req        <= '0;
		gaps_on    = 1'b1;
		n_requests = 0;
		n_reused   = 0;
		hdr_count  = 0;
		pool_top   = 0;
		for (int i = 0; i < 4; i++)
			stat_seen[i] = 0;
		for (int i = 0; i < KBA_MAX_ENTRIES; i++)
			hdr_live[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mixed_traffic(250);
		test_pool_exhaustion();
		test_table_full();
		test_full_table_traffic(330, 100);

		wait_idle();
		repeat (KBA_MAX_ENTRIES + 8) @(posedge clk);
		$display("covered %0d requests: %0d ok (%0d by reuse), %0d not found",
			n_requests, stat_seen[STAT_OK], n_reused, stat_seen[STAT_NOT_FOUND]);
		$display("%0d table-full and %0d pool-full answers, %0d headers, pool top %0d",
			stat_seen[STAT_TABLE_FULL], stat_seen[STAT_POOL_FULL], hdr_count, pool_top);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches seen", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
